[design/ppts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared types and constants for the preemptive priority task scheduler.
// ----------------------------------------------------------------------------
package ppts_pkg;

   localparam int MAX_TASKS  = 16;
   localparam int SLOT_BITS  = $clog2(MAX_TASKS);
   localparam int TIME_BITS  = 16;
   localparam int PRIO_BITS  = 8;
   localparam int COUNT_BITS = 5;
   localparam int KIND_BITS  = 2;

   localparam logic [TIME_BITS-1:0]  TIME_MAX = {TIME_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] DONE_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] SLOTS_MAX = COUNT_BITS'(MAX_TASKS);

   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [PRIO_BITS-1:0]  prio_type;
   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_LOAD    = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      time_type arrival;
      prio_type prio;
      time_type remaining;
      logic     started;
      time_type start;
   } entry_type;

endpackage

[design/preemptive_priority_task_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_task_scheduler
// Task table in a synchronous memory; each tick scans the slots in use,
// picks the ready task of highest priority, runs it one unit and writes back.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/stall    | kind slot arrival priority_level burst
//  rsp_    | out       | rsp_valid/stall    | ran ran_slot first_run finished
//          |           |                    | time_after start_at end_at all_done
//  csr_    | in        | csr_we             | csr_wdata (task_count)
//
// load, restart and other kinds: result registered, valid in the cycle after accept.
// tick: the one-slot-per-cycle scan of the table memory covers the slots in
// use (one read per cycle, registered read data), then commit writes back.
// one item at a time; a new item is taken once the block is idle and the
// output register is free or being drained. reset is synchronous; the busy
// bits clear at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module preemptive_priority_task_scheduler (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ppts_pkg::KIND_BITS-1:0]  req_kind,
   input  logic [ppts_pkg::SLOT_BITS-1:0]  req_slot,
   input  logic [ppts_pkg::TIME_BITS-1:0]  req_arrival,
   input  logic [ppts_pkg::PRIO_BITS-1:0]  req_priority_level,
   input  logic [ppts_pkg::TIME_BITS-1:0]  req_burst,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_ran,
   output logic [ppts_pkg::SLOT_BITS-1:0]  rsp_ran_slot,
   output logic                      rsp_first_run,
   output logic                      rsp_finished,
   output logic [ppts_pkg::TIME_BITS-1:0]  rsp_time_after,
   output logic [ppts_pkg::TIME_BITS-1:0]  rsp_start_at,
   output logic [ppts_pkg::TIME_BITS-1:0]  rsp_end_at,
   output logic                      rsp_all_done,
   input  logic                      csr_we,
   input  logic [ppts_pkg::COUNT_BITS-1:0] csr_wdata
);
   import ppts_pkg::*;

   entry_type mem [MAX_TASKS];
   entry_type rd_data_ff;

   state_type state_ff, state_in;
   count_type task_count_ff;
   time_type  clock_ff, clock_in;
   count_type done_ff, done_in;
   logic [MAX_TASKS-1:0] busy_ff, busy_in;
   count_type scan_idx_ff, scan_idx_in;
   logic      rdv_ff, rdv_in;
   slot_type  rd_slot_ff;
   logic      found_ff, found_in;
   entry_type best_ff, best_in;
   slot_type  best_slot_ff, best_slot_in;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_load;
   logic      o_ran, o_first, o_fin, o_all_done;
   slot_type  o_slot;
   time_type  o_time, o_start, o_end;
   logic      rsp_ran_ff, rsp_first_ff, rsp_fin_ff, rsp_all_done_ff;
   slot_type  rsp_slot_ff;
   time_type  rsp_time_ff, rsp_start_ff, rsp_end_ff;

   logic      mem_we;
   slot_type  mem_waddr;
   entry_type mem_wdata;

   count_type n_used;
   logic [MAX_TASKS-1:0] use_mask;
   logic      out_free, req_take, cand, better;
   kind_type  kind;
   entry_type upd;
   time_type  clock_sat;

   assign kind      = kind_type'(req_kind);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;
   assign n_used    = (task_count_ff > SLOTS_MAX) ? SLOTS_MAX : task_count_ff;
   assign clock_sat = (clock_ff == TIME_MAX) ? TIME_MAX : clock_ff + 1'b1;

   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         use_mask[i] = (COUNT_BITS'(i) < n_used);
      end
   end

   assign cand   = rdv_ff && busy_ff[rd_slot_ff] && (rd_data_ff.arrival <= clock_ff);
   assign better = !found_ff || (rd_data_ff.prio > best_ff.prio) ||
                   ((rd_data_ff.prio == best_ff.prio) &&
                    (rd_data_ff.arrival < best_ff.arrival));

   always_comb begin
      state_in     = state_ff;
      clock_in     = clock_ff;
      done_in      = done_ff;
      busy_in      = busy_ff;
      scan_idx_in  = scan_idx_ff;
      rdv_in       = 1'b0;
      found_in     = found_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_load     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = req_slot;
      mem_wdata    = '0;
      upd          = best_ff;
      o_ran        = 1'b0;
      o_slot       = '0;
      o_first      = 1'b0;
      o_fin        = 1'b0;
      o_start      = '0;
      o_end        = '0;
      o_time       = clock_ff;
      o_all_done   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (kind)
                  KIND_LOAD: begin
                     mem_we              = 1'b1;
                     mem_wdata.arrival   = req_arrival;
                     mem_wdata.prio      = req_priority_level;
                     mem_wdata.remaining = req_burst;
                     busy_in[req_slot]   = (req_burst != '0);
                  end
                  KIND_TICK: begin
                     state_in    = ST_SCAN;
                     scan_idx_in = '0;
                     found_in    = 1'b0;
                  end
                  KIND_RESTART: begin
                     clock_in = '0;
                     done_in  = '0;
                  end
                  default: begin
                  end
               endcase
               if (kind != KIND_TICK) begin
                  o_time       = clock_in;
                  o_all_done   = ((busy_in & use_mask) == '0);
                  rsp_load     = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (cand && better) begin
               found_in     = 1'b1;
               best_in      = rd_data_ff;
               best_slot_in = rd_slot_ff;
            end
            if (scan_idx_ff < n_used) begin
               rdv_in      = 1'b1;
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
               clock_in = clock_sat;
               if (found_ff) begin
                  upd.started   = 1'b1;
                  upd.start     = best_ff.started ? best_ff.start : clock_ff;
                  upd.remaining = best_ff.remaining - 1'b1;
                  mem_we        = 1'b1;
                  mem_waddr     = best_slot_ff;
                  mem_wdata     = upd;
                  o_ran         = 1'b1;
                  o_slot        = best_slot_ff;
                  o_first       = !best_ff.started;
                  o_start       = upd.start;
                  if (upd.remaining == '0) begin
                     o_fin                 = 1'b1;
                     o_end                 = clock_sat;
                     busy_in[best_slot_ff] = 1'b0;
                     if (done_ff != DONE_MAX) begin
                        done_in = done_ff + 1'b1;
                     end
                  end
               end
               o_time       = clock_sat;
               o_all_done   = ((busy_in & use_mask) == '0);
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_idx_ff[SLOT_BITS-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         task_count_ff <= '0;
         clock_ff      <= '0;
         done_ff       <= '0;
         busy_ff       <= '0;
         scan_idx_ff   <= '0;
         rdv_ff        <= 1'b0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            task_count_ff <= csr_wdata;
         end
         clock_ff     <= clock_in;
         done_ff      <= done_in;
         busy_ff      <= busy_in;
         scan_idx_ff  <= scan_idx_in;
         rdv_ff       <= rdv_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_slot_ff   <= scan_idx_ff[SLOT_BITS-1:0];
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      if (rsp_load) begin
         rsp_ran_ff      <= o_ran;
         rsp_slot_ff     <= o_slot;
         rsp_first_ff    <= o_first;
         rsp_fin_ff      <= o_fin;
         rsp_time_ff     <= o_time;
         rsp_start_ff    <= o_start;
         rsp_end_ff      <= o_end;
         rsp_all_done_ff <= o_all_done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ran        = rsp_ran_ff;
   assign rsp_ran_slot   = rsp_slot_ff;
   assign rsp_first_run  = rsp_first_ff;
   assign rsp_finished   = rsp_fin_ff;
   assign rsp_time_after = rsp_time_ff;
   assign rsp_start_at   = rsp_start_ff;
   assign rsp_end_at     = rsp_end_ff;
   assign rsp_all_done   = rsp_all_done_ff;

endmodule

[test/preemptive_priority_task_scheduler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_task_scheduler_tb
// Runs a short table of directed items first: idle ticks, an unknown kind,
// restart, tie breaks, a late high priority arrival, a zero burst, and task
// counts of 0, 4, 16 and 31. Random task sets with random tick runs and
// noise follow. Each result is checked against a cycle-free scheduler
// model in the bench, or against the want of a typed table row.
// The sender works in bursts with gaps, and the receiver stalls at random.
// ----------------------------------------------------------------------------
module preemptive_priority_task_scheduler_tb;
   import ppts_pkg::*;

   typedef struct packed {
      logic     ran;
      slot_type ran_slot;
      logic     first_run;
      logic     finished;
      time_type time_after;
      time_type start_at;
      time_type end_at;
      logic     all_done;
   } sched_result_t;

   typedef struct {
      bit            csr_row;
      count_type     csr_value;
      kind_type      kind;
      slot_type      slot;
      time_type      arrival;
      prio_type      prio;
      time_type      burst;
      bit            typed;
      sched_result_t want;
   } step_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KIND_BITS-1:0]  req_kind = '0;
   slot_type              req_slot = '0;
   time_type              req_arrival = '0;
   prio_type              req_priority_level = '0;
   time_type              req_burst = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_ran;
   slot_type              rsp_ran_slot;
   logic                  rsp_first_run;
   logic                  rsp_finished;
   time_type              rsp_time_after;
   time_type              rsp_start_at;
   time_type              rsp_end_at;
   logic                  rsp_all_done;
   logic                  csr_we = 1'b0;
   count_type             csr_wdata = '0;

   // sideband that travels with the item on the request channel
   bit                    req_typed = 1'b0;
   sched_result_t         req_want = '0;

   // scheduler model state
   count_type             sched_count = '0;
   time_type              sched_arrival [MAX_TASKS];
   prio_type              sched_prio [MAX_TASKS];
   time_type              sched_left [MAX_TASKS];
   bit                    sched_started [MAX_TASKS];
   time_type              sched_start [MAX_TASKS];
   time_type              sched_clock = '0;
   count_type             sched_done = '0;

   sched_result_t         pending_results [$];
   int                    mismatches = 0;
   int                    items_sent = 0;
   int                    burst_left = 0;
   int                    stall_run = 0;

   // csr rows carry the register value, typed rows their expected result
   step_row_t plan [25] = '{
      '{1'b0, 5'd0, KIND_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 1'b1,
        '{1'b0, 4'd0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd0, 1'b1}},
      '{1'b0, 5'd0, KIND_NONE, 4'd15, 16'hffff, 8'hff, 16'hffff, 1'b1,
        '{1'b0, 4'd0, 1'b0, 1'b0, 16'd1, 16'd0, 16'd0, 1'b1}},
      '{1'b0, 5'd0, KIND_RESTART, 4'd0, 16'd0, 8'd0, 16'd0, 1'b1,
        '{1'b0, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1}},
      '{1'b1, 5'd4, KIND_NONE, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0},
      '{1'b0, 5'd0, KIND_LOAD, 4'd0, 16'd0, 8'd5, 16'd2, 1'b1,
        '{1'b0, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b0}},
      '{1'b0, 5'd0, KIND_LOAD, 4'd1, 16'd0, 8'd5, 16'd1, 1'b0, '0},
      '{1'b0, 5'd0, KIND_LOAD, 4'd2, 16'd1, 8'd9, 16'd1, 1'b0, '0},
      // zero burst at top priority never runs
      '{1'b0, 5'd0, KIND_LOAD, 4'd3, 16'd0, 8'd200, 16'd0, 1'b0, '0},
      '{1'b0, 5'd0, KIND_LOAD, 4'd15, 16'hffff, 8'hff, 16'hffff, 1'b0, '0},
      '{1'b0, 5'd0, KIND_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 1'b1,
        '{1'b1, 4'd0, 1'b1, 1'b0, 16'd1, 16'd0, 16'd0, 1'b0}},
      '{1'b0, 5'd0, KIND_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0},
      '{1'b0, 5'd0, KIND_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0},
      '{1'b0, 5'd0, KIND_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0},
      '{1'b0, 5'd0, KIND_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 1'b1,
        '{1'b0, 4'd0, 1'b0, 1'b0, 16'd5, 16'd0, 16'd0, 1'b1}},
      '{1'b0, 5'd0, KIND_RESTART, 4'd0, 16'd0, 8'd0, 16'd0, 1'b1,
        '{1'b0, 4'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 1'b1}},
      '{1'b1, 5'd31, KIND_NONE, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0},
      '{1'b0, 5'd0, KIND_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0},
      '{1'b0, 5'd0, KIND_LOAD, 4'd4, 16'd1, 8'd0, 16'd1, 1'b0, '0},
      '{1'b0, 5'd0, KIND_LOAD, 4'd5, 16'd0, 8'd0, 16'd1, 1'b0, '0},
      '{1'b0, 5'd0, KIND_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0},
      '{1'b0, 5'd0, KIND_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0},
      '{1'b0, 5'd0, KIND_LOAD, 4'd15, 16'd0, 8'd0, 16'd1, 1'b0, '0},
      '{1'b0, 5'd0, KIND_TICK, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0},
      '{1'b1, 5'd16, KIND_NONE, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0},
      '{1'b0, 5'd0, KIND_NONE, 4'd0, 16'd0, 8'd0, 16'd0, 1'b0, '0}
   };

   preemptive_priority_task_scheduler u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_slot           (req_slot),
      .req_arrival        (req_arrival),
      .req_priority_level (req_priority_level),
      .req_burst          (req_burst),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ran            (rsp_ran),
      .rsp_ran_slot       (rsp_ran_slot),
      .rsp_first_run      (rsp_first_run),
      .rsp_finished       (rsp_finished),
      .rsp_time_after     (rsp_time_after),
      .rsp_start_at       (rsp_start_at),
      .rsp_end_at         (rsp_end_at),
      .rsp_all_done       (rsp_all_done),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         sched_arrival[i] = '0;
         sched_prio[i] = '0;
         sched_left[i] = '0;
         sched_started[i] = 1'b0;
         sched_start[i] = '0;
      end
   end

   function automatic time_type next_clock(time_type t);
      return (t == TIME_MAX) ? TIME_MAX : t + 1'b1;
   endfunction

   function automatic sched_result_t predict_schedule(kind_type k, slot_type s,
         time_type a, prio_type p, time_type b);
      sched_result_t r;
      int            n;
      int            pick;
      r = '0;
      n = (sched_count > SLOTS_MAX) ? MAX_TASKS : int'(sched_count);
      case (k)
         KIND_LOAD: begin
            sched_arrival[s] = a;
            sched_prio[s] = p;
            sched_left[s] = b;
            sched_started[s] = 1'b0;
            sched_start[s] = '0;
         end
         KIND_TICK: begin
            pick = -1;
            for (int i = 0; i < n; i++) begin
               if (sched_left[i] != 0 && sched_arrival[i] <= sched_clock) begin
                  if (pick < 0 || sched_prio[i] > sched_prio[pick] ||
                      (sched_prio[i] == sched_prio[pick] &&
                       sched_arrival[i] < sched_arrival[pick]))
                     pick = i;
               end
            end
            if (pick >= 0) begin
               r.ran = 1'b1;
               r.ran_slot = slot_type'(pick);
               if (!sched_started[pick]) begin
                  sched_started[pick] = 1'b1;
                  sched_start[pick] = sched_clock;
                  r.first_run = 1'b1;
               end
               sched_left[pick] = sched_left[pick] - 1'b1;
               sched_clock = next_clock(sched_clock);
               r.start_at = sched_start[pick];
               if (sched_left[pick] == 0) begin
                  r.finished = 1'b1;
                  r.end_at = sched_clock;
                  if (sched_done != DONE_MAX)
                     sched_done = sched_done + 1'b1;
               end
            end else begin
               sched_clock = next_clock(sched_clock);
            end
         end
         KIND_RESTART: begin
            sched_clock = '0;
            sched_done = '0;
         end
         default: ;
      endcase
      r.time_after = sched_clock;
      r.all_done = 1'b1;
      for (int i = 0; i < n; i++)
         if (sched_left[i] != 0)
            r.all_done = 1'b0;
      return r;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
         if (mismatches < 10)
            $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
         mismatches++;
      end
   endtask

   // monitor: model update on each accepted item, compare on each result
   always @(posedge clock) begin
      sched_result_t want;
      if (!reset) begin
         if (csr_we)
            sched_count = csr_wdata;
         if (req_valid && !req_stall) begin
            want = predict_schedule(kind_type'(req_kind), req_slot, req_arrival,
                                    req_priority_level, req_burst);
            if (req_typed)
               want = req_want;
            pending_results.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: result with no item outstanding", $time);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("ran", 16'(want.ran), 16'(rsp_ran));
               check_field("ran_slot", 16'(want.ran_slot), 16'(rsp_ran_slot));
               check_field("first_run", 16'(want.first_run), 16'(rsp_first_run));
               check_field("finished", 16'(want.finished), 16'(rsp_finished));
               check_field("time_after", want.time_after, rsp_time_after);
               check_field("start_at", want.start_at, rsp_start_at);
               check_field("end_at", want.end_at, rsp_end_at);
               check_field("all_done", 16'(want.all_done), 16'(rsp_all_done));
            end
         end
      end
   end

   // receiver: runs of stall and runs of free cycles
   always @(posedge clock) begin
      if (stall_run != 0) begin
         stall_run <= stall_run - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_run <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
         stall_run <= $urandom_range(0, 24);
      end
   end

   task automatic send_item(kind_type k, slot_type s, time_type a, prio_type p,
         time_type b, bit typed, sched_result_t want);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_kind <= k;
      req_slot <= s;
      req_arrival <= a;
      req_priority_level <= p;
      req_burst <= b;
      req_typed <= typed;
      req_want <= want;
      do @(posedge clock); while (req_stall);
      if (k != KIND_NONE)
         items_sent++;
   endtask

   // wait until every result is back, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_task_count(count_type v);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic time_type pick_arrival();
      return ($urandom_range(0, 15) == 0) ? time_type'($urandom_range(0, 65535))
                                          : time_type'($urandom_range(0, 10));
   endfunction

   function automatic prio_type pick_prio();
      return ($urandom_range(0, 3) == 0) ? prio_type'($urandom_range(0, 255))
                                         : prio_type'($urandom_range(0, 2));
   endfunction

   function automatic time_type pick_burst();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0)
         return '0;
      if (r == 1)
         return time_type'($urandom_range(0, 65535));
      return time_type'($urandom_range(1, 5));
   endfunction

   task automatic send_noise(kind_type k);
      send_item(k, slot_type'($urandom_range(0, 15)), time_type'($urandom_range(0, 65535)),
                prio_type'($urandom_range(0, 255)), time_type'($urandom_range(0, 65535)),
                1'b0, '0);
   endtask

   initial begin
      int       r;
      int       n;
      int       in_use;
      int       work;
      int       ticks;
      int       random_start;
      time_type b;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(plan); i++) begin
         if (plan[i].csr_row)
            write_task_count(plan[i].csr_value);
         else
            send_item(plan[i].kind, plan[i].slot, plan[i].arrival, plan[i].prio,
                      plan[i].burst, plan[i].typed, plan[i].want);
      end

      random_start = items_sent;
      while (items_sent - random_start < 1900) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            n = 0;
         else if (r == 1)
            n = $urandom_range(17, 31);
         else if (r == 2)
            n = MAX_TASKS;
         else
            n = $urandom_range(1, 8);
         write_task_count(count_type'(n));
         in_use = (n > MAX_TASKS) ? MAX_TASKS : n;
         if ($urandom_range(0, 3) != 0)
            send_noise(KIND_RESTART);
         work = 0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            if (i < in_use ? $urandom_range(0, 4) != 0 : $urandom_range(0, 7) == 0) begin
               b = pick_burst();
               if (b <= 16)
                  work += b;
               send_item(KIND_LOAD, slot_type'(i), pick_arrival(), pick_prio(), b,
                         1'b0, '0);
            end
         end
         ticks = work + $urandom_range(1, 6);
         if (ticks > 80)
            ticks = 80;
         for (int i = 0; i < ticks; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0)
               send_noise(KIND_NONE);
            else if (r == 1)
               send_item(KIND_LOAD, slot_type'($urandom_range(0, 15)), pick_arrival(),
                         pick_prio(), pick_burst(), 1'b0, '0);
            else if (r == 2)
               send_noise(KIND_RESTART);
            else
               send_noise(KIND_TICK);
         end
      end

      settle();
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #(40_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule
